// ----- design/ffha_pkg.sv -----
package ffha_pkg;

    localparam int SIZE_W = 32;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [SIZE_W-1:0] HDR_BYTES  = 32'd4;
    localparam logic [SIZE_W-1:0] MIN_BLOCK  = 32'd8;
    localparam logic [SIZE_W-1:0] MIN_REGION = 32'd16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_A_RD,
        S_A_CMP,
        S_A_FIT,
        S_FSH_RD,
        S_FSH_WR,
        S_F_CHK,
        S_U_RD,
        S_U_CMP,
        S_P_RD,
        S_P_CMP,
        S_F_DEC,
        S_USH_RD,
        S_USH_WR,
        S_F_UPD,
        S_FUP_RD,
        S_FUP_WR,
        S_DONE
    } state_t;

endpackage

// ----- design/ffha_table.sv -----
module ffha_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// channel | signals                                   | direction
// in      | in_valid, in_stall, opcode, request_size, | into block
//         | block_addr                                |
// out     | out_valid, out_stall, result_addr, status | out of block
// cfg     | cfg_wr_en, cfg_index, cfg_wdata           | into block
// an item keeps the block busy through its table scans and shift steps;
// each step is a read state then a compare or write state on the registered read port
// in_stall is high from acceptance until the result moves into the output register
// a result waits in the output register while the next item is taken
// reset clears the counts and control state; table contents stay undefined
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_FREE_BLOCKS = 16,
    parameter int MAX_USED_BLOCKS = 16,
    parameter int ADDR_WIDTH      = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [SIZE_W-1:0]   block_addr,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SIZE_W-1:0]   result_addr,
    output logic [1:0]          status,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [SIZE_W-1:0]   cfg_wdata
);

    localparam int AW   = ADDR_WIDTH;
    localparam int EW   = AW + SIZE_W;
    localparam int FIW  = $clog2(MAX_FREE_BLOCKS);
    localparam int UIW  = $clog2(MAX_USED_BLOCKS);
    localparam int FCW  = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int UCW  = $clog2(MAX_USED_BLOCKS + 1);
    localparam int CMPW = (AW > SIZE_W) ? AW : SIZE_W;
    localparam logic [FCW-1:0] FMAX = FCW'(MAX_FREE_BLOCKS);
    localparam logic [UCW-1:0] UMAX = UCW'(MAX_USED_BLOCKS);

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] base_reg, size_reg;
    logic [FCW-1:0] fcount_reg, fcount_next;
    logic [UCW-1:0] ucount_reg, ucount_next;
    logic [FCW-1:0] fk_reg, fk_next, sk_reg, sk_next;
    logic [UCW-1:0] uk_reg, uk_next;
    logic [SIZE_W:0] need_reg, need_next;
    logic [AW-1:0] blk_reg, blk_next;
    logic [SIZE_W-1:0] bsize_reg, bsize_next;
    logic [1:0] op_reg, op_next;
    logic [AW-1:0] prev_start_reg, prev_start_next, next_start_reg, next_start_next;
    logic [SIZE_W-1:0] prev_size_reg, prev_size_next, next_size_reg, next_size_next;
    logic has_next_reg, has_next_next;
    logic jn_reg, jn_next, jp_reg, jp_next;
    logic [SIZE_W-1:0] res_addr_reg, res_addr_next;
    logic [1:0] res_st_reg, res_st_next;
    logic out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] out_addr_reg, out_addr_next;
    logic [1:0] out_st_reg, out_st_next;

    logic           f_we, u_we;
    logic [FIW-1:0] f_waddr, f_raddr;
    logic [UIW-1:0] u_waddr, u_raddr;
    logic [EW-1:0]  f_wdata, f_rdata, u_wdata, u_rdata;
    logic [AW-1:0]  f_rd_start, u_rd_start;
    logic [SIZE_W-1:0] f_rd_size, u_rd_size;
    logic [SIZE_W:0]   need_raw;
    logic [AW-1:0]     off;
    logic [SIZE_W-1:0] rem;

    assign f_rd_start = f_rdata[EW-1:SIZE_W];
    assign f_rd_size  = f_rdata[SIZE_W-1:0];
    assign u_rd_start = u_rdata[EW-1:SIZE_W];
    assign u_rd_size  = u_rdata[SIZE_W-1:0];

    ffha_table #(.DEPTH(MAX_FREE_BLOCKS), .WIDTH(EW)) u_free_tab (
        .clk     (clk),
        .wr_en   (f_we),
        .wr_addr (f_waddr),
        .wr_data (f_wdata),
        .rd_addr (f_raddr),
        .rd_data (f_rdata)
    );

    ffha_table #(.DEPTH(MAX_USED_BLOCKS), .WIDTH(EW)) u_used_tab (
        .clk     (clk),
        .wr_en   (u_we),
        .wr_addr (u_waddr),
        .wr_data (u_wdata),
        .rd_addr (u_raddr),
        .rd_data (u_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            size_reg      <= '0;
            fcount_reg    <= '0;
            ucount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcount_reg    <= fcount_next;
            ucount_reg    <= ucount_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                if (cfg_index)
                begin
                    size_reg <= cfg_wdata;
                end
                else
                begin
                    base_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fk_reg         <= fk_next;
        sk_reg         <= sk_next;
        uk_reg         <= uk_next;
        need_reg       <= need_next;
        blk_reg        <= blk_next;
        bsize_reg      <= bsize_next;
        op_reg         <= op_next;
        prev_start_reg <= prev_start_next;
        prev_size_reg  <= prev_size_next;
        next_start_reg <= next_start_next;
        next_size_reg  <= next_size_next;
        has_next_reg   <= has_next_next;
        jn_reg         <= jn_next;
        jp_reg         <= jp_next;
        res_addr_reg   <= res_addr_next;
        res_st_reg     <= res_st_next;
        out_addr_reg   <= out_addr_next;
        out_st_reg     <= out_st_next;
    end

    // size + header rounded up to a word; raised to one minimum block when an item is taken
    assign need_raw = (({1'b0, request_size} + 33'd7) & ~33'd3);
    assign off      = blk_reg - AW'(base_reg);
    assign rem      = bsize_reg - need_reg[SIZE_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        fcount_next     = fcount_reg;
        ucount_next     = ucount_reg;
        fk_next         = fk_reg;
        sk_next         = sk_reg;
        uk_next         = uk_reg;
        need_next       = need_reg;
        blk_next        = blk_reg;
        bsize_next      = bsize_reg;
        op_next         = op_reg;
        prev_start_next = prev_start_reg;
        prev_size_next  = prev_size_reg;
        next_start_next = next_start_reg;
        next_size_next  = next_size_reg;
        has_next_next   = has_next_reg;
        jn_next         = jn_reg;
        jp_next         = jp_reg;
        res_addr_next   = res_addr_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_addr_next   = out_addr_reg;
        out_st_next     = out_st_reg;
        f_we            = 1'b0;
        f_waddr         = fk_reg[FIW-1:0];
        f_wdata         = f_rdata;
        f_raddr         = fk_reg[FIW-1:0];
        u_we            = 1'b0;
        u_waddr         = uk_reg[UIW-1:0];
        u_wdata         = u_rdata;
        u_raddr         = uk_reg[UIW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    res_addr_next = '0;
                    fk_next       = '0;
                    uk_next       = '0;
                    need_next     = (need_raw < {1'b0, MIN_BLOCK}) ? {1'b0, MIN_BLOCK}
                                                                   : need_raw;
                    blk_next      = AW'(block_addr) - AW'(HDR_BYTES);
                    case (opcode)
                        OP_INIT:  state_next = S_INIT;
                        OP_ALLOC: state_next = S_A_RD;
                        OP_FREE:  state_next = S_F_CHK;
                        default:
                        begin
                            res_st_next = ST_FAIL;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                fcount_next = '0;
                ucount_next = '0;
                if (size_reg < MIN_REGION)
                begin
                    res_st_next = ST_FAIL;
                end
                else
                begin
                    f_we        = 1'b1;
                    f_waddr     = '0;
                    f_wdata     = {AW'(base_reg) + AW'(MIN_BLOCK), size_reg - MIN_BLOCK};
                    fcount_next = FCW'(1);
                    res_st_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_A_RD:
            begin
                if (fk_reg < fcount_reg)
                begin
                    state_next = S_A_CMP;
                end
                else
                begin
                    res_st_next = ST_FAIL;
                    state_next  = S_DONE;
                end
            end
            S_A_CMP:
            begin
                if ({1'b0, f_rd_size} >= need_reg)
                begin
                    blk_next   = f_rd_start;
                    bsize_next = f_rd_size;
                    state_next = S_A_FIT;
                end
                else
                begin
                    fk_next    = fk_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_A_FIT:
            begin
                if (ucount_reg >= UMAX)
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    res_addr_next = SIZE_W'(blk_reg + AW'(HDR_BYTES));
                    res_st_next   = ST_OK;
                    ucount_next   = ucount_reg + 1'b1;
                    u_we          = 1'b1;
                    u_waddr       = ucount_reg[UIW-1:0];
                    if (rem >= MIN_BLOCK)
                    begin
                        // split: the tail stays in the free table
                        f_we       = 1'b1;
                        f_wdata    = {blk_reg + AW'(need_reg), rem};
                        u_wdata    = {blk_reg, need_reg[SIZE_W-1:0]};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        u_wdata    = {blk_reg, bsize_reg};
                        state_next = S_FSH_RD;
                    end
                end
            end
            S_FSH_RD:
            begin
                f_raddr = FIW'(fk_reg + 1'b1);
                if ((fk_reg + 1'b1) < fcount_reg)
                begin
                    state_next = S_FSH_WR;
                end
                else
                begin
                    fcount_next = fcount_reg - 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_FSH_WR:
            begin
                f_we       = 1'b1;
                fk_next    = fk_reg + 1'b1;
                state_next = S_FSH_RD;
            end
            S_F_CHK:
            begin
                if (off < AW'(MIN_BLOCK) || CMPW'(off) >= CMPW'(size_reg))
                begin
                    res_st_next = ST_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_U_RD;
                end
            end
            S_U_RD:
            begin
                if (uk_reg < ucount_reg)
                begin
                    state_next = S_U_CMP;
                end
                else
                begin
                    res_st_next = ST_UNKNOWN;
                    state_next  = S_DONE;
                end
            end
            S_U_CMP:
            begin
                if (u_rd_start == blk_reg)
                begin
                    bsize_next    = u_rd_size;
                    has_next_next = 1'b0;
                    state_next    = S_P_RD;
                end
                else
                begin
                    uk_next    = uk_reg + 1'b1;
                    state_next = S_U_RD;
                end
            end
            S_P_RD:
            begin
                if (fk_reg < fcount_reg)
                begin
                    state_next = S_P_CMP;
                end
                else
                begin
                    state_next = S_F_DEC;
                end
            end
            S_P_CMP:
            begin
                if (f_rd_start > blk_reg)
                begin
                    next_start_next = f_rd_start;
                    next_size_next  = f_rd_size;
                    has_next_next   = 1'b1;
                    state_next      = S_F_DEC;
                end
                else
                begin
                    prev_start_next = f_rd_start;
                    prev_size_next  = f_rd_size;
                    fk_next         = fk_reg + 1'b1;
                    state_next      = S_P_RD;
                end
            end
            S_F_DEC:
            begin
                jn_next = has_next_reg && (next_start_reg == blk_reg + AW'(bsize_reg));
                jp_next = (fk_reg != '0) && (prev_start_reg + AW'(prev_size_reg) == blk_reg);
                if (!jn_next && !jp_next && fcount_reg >= FMAX)
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_USH_RD;
                end
            end
            S_USH_RD:
            begin
                u_raddr = UIW'(uk_reg + 1'b1);
                if ((uk_reg + 1'b1) < ucount_reg)
                begin
                    state_next = S_USH_WR;
                end
                else
                begin
                    ucount_next = ucount_reg - 1'b1;
                    state_next  = S_F_UPD;
                end
            end
            S_USH_WR:
            begin
                u_we       = 1'b1;
                uk_next    = uk_reg + 1'b1;
                state_next = S_USH_RD;
            end
            S_F_UPD:
            begin
                res_st_next = ST_OK;
                if (jn_reg && jp_reg)
                begin
                    // both neighbours fold into the lower one, upper entry removed
                    f_we       = 1'b1;
                    f_waddr    = FIW'(fk_reg - 1'b1);
                    f_wdata    = {prev_start_reg, prev_size_reg + next_size_reg + bsize_reg};
                    state_next = S_FSH_RD;
                end
                else if (jn_reg)
                begin
                    f_we       = 1'b1;
                    f_wdata    = {blk_reg, next_size_reg + bsize_reg};
                    state_next = S_DONE;
                end
                else if (jp_reg)
                begin
                    f_we       = 1'b1;
                    f_waddr    = FIW'(fk_reg - 1'b1);
                    f_wdata    = {prev_start_reg, prev_size_reg + bsize_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    sk_next    = fcount_reg;
                    state_next = S_FUP_RD;
                end
            end
            S_FUP_RD:
            begin
                f_raddr = FIW'(sk_reg - 1'b1);
                if (sk_reg > fk_reg)
                begin
                    state_next = S_FUP_WR;
                end
                else
                begin
                    f_we        = 1'b1;
                    f_wdata     = {blk_reg, bsize_reg};
                    fcount_next = fcount_reg + 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_FUP_WR:
            begin
                f_we       = 1'b1;
                f_waddr    = sk_reg[FIW-1:0];
                sk_next    = sk_reg - 1'b1;
                state_next = S_FUP_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_addr = out_addr_reg;
    assign status      = out_st_reg;

`ifndef SYNTHESIS
    a_fcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= FMAX)
        else $error("free count above table depth");

    a_ucount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ucount_reg <= UMAX)
        else $error("used count above table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("block idle right after a transaction");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result presented without a finished operation");
`endif

endmodule
